@@ src/vad_pkg.sv @@
// Shared constants, coefficient lookup and widths for the VAG ADPCM decoder.
package vad_pkg;

    localparam int BLOCK_SAMPLES  = 28;
    localparam int BLOCK_BYTES    = 2 + BLOCK_SAMPLES / 2;
    localparam int POS_W          = $clog2(BLOCK_BYTES);
    localparam int HIST_INT_BITS  = 18;
    localparam int COEF_W         = 8;
    localparam int COEF_SHIFT     = 6;
    localparam int NUM_FILTERS    = 5;
    localparam int NIBBLE_SHIFT   = 12;

    localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
    localparam logic [POS_W-1:0] POS_FLAG   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BLOCK_BYTES - 1);
    localparam logic [7:0]       END_FLAG   = 8'h07;

    typedef logic [2:0] filt_idx_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    // Predictor coefficients in units of 1/64, first tap.
    function automatic coef_t coef_first(input filt_idx_t idx);
        coef_t c;
        case (idx)
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            3'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    // Second tap.
    function automatic coef_t coef_second(input filt_idx_t idx);
        coef_t c;
        case (idx)
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            3'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    // Map the header's filter nibble; out-of-range indices select no prediction.
    function automatic filt_idx_t filt_select(input logic [3:0] nib);
        filt_idx_t f;
        if (nib < 4'(NUM_FILTERS)) begin
            f = nib[2:0];
        end else begin
            f = 3'd0;
        end
        return f;
    endfunction

endpackage

@@ src/vad_nibble_filter.sv @@
// One ADPCM filter step: scale a nibble, add the two-tap prediction, round to a sample.
module vad_nibble_filter #(
    parameter int FRAC_BITS = 6,
    localparam int HIST_BITS = vad_pkg::HIST_INT_BITS + FRAC_BITS
) (
    input  logic [3:0]                  nibble,
    input  logic [3:0]                  shift,
    input  vad_pkg::filt_idx_t          filt,
    input  logic signed [HIST_BITS-1:0] hist_one,
    input  logic signed [HIST_BITS-1:0] hist_two,
    output logic signed [HIST_BITS-1:0] acc,
    output logic signed [15:0]          sample
);
    import vad_pkg::*;

    localparam int PSUM_W = HIST_BITS + COEF_W + 1;
    localparam int ACC_W  = HIST_BITS + 4;
    localparam int RND_W  = HIST_BITS + 2;

    localparam logic signed [ACC_W-1:0] HMAX = ACC_W'((64'sd1 <<< (HIST_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] HMIN = ACC_W'(-(64'sd1 <<< (HIST_BITS - 1)));
    localparam logic signed [RND_W-1:0] HALF = RND_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [RND_W-1:0] TRUNC_ADJ = RND_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [RND_W-1:0] SMAX = RND_W'(32767);
    localparam logic signed [RND_W-1:0] SMIN = RND_W'(-32768);

    logic signed [15:0]       raw_top;
    logic signed [15:0]       raw;
    coef_t                    c0;
    coef_t                    c1;
    logic signed [PSUM_W-1:0] prod_one;
    logic signed [PSUM_W-1:0] prod_two;
    logic signed [PSUM_W-1:0] pred_sum;
    logic signed [PSUM_W-1:0] pred;
    logic signed [ACC_W-1:0]  acc_wide;
    logic signed [RND_W-1:0]  rnd;
    logic signed [RND_W-1:0]  quot;

    always_comb begin
        raw_top  = signed'({nibble, 12'b0});
        raw      = raw_top >>> shift;
        c0       = coef_first(filt);
        c1       = coef_second(filt);
        prod_one = PSUM_W'(hist_one) * PSUM_W'(c0);
        prod_two = PSUM_W'(hist_two) * PSUM_W'(c1);
        pred_sum = prod_one + prod_two;
        pred     = pred_sum >>> COEF_SHIFT;
        acc_wide = ACC_W'(pred) + (ACC_W'(raw) <<< FRAC_BITS);

        if (acc_wide > HMAX) begin
            acc = HIST_BITS'(HMAX);
        end else if (acc_wide < HMIN) begin
            acc = HIST_BITS'(HMIN);
        end else begin
            acc = HIST_BITS'(acc_wide);
        end

        // round half up, then truncate toward zero
        rnd = RND_W'(acc) + HALF;
        if (rnd < 0) begin
            quot = (rnd + TRUNC_ADJ) >>> FRAC_BITS;
        end else begin
            quot = rnd >>> FRAC_BITS;
        end

        if (quot > SMAX) begin
            sample = 16'sh7fff;
        end else if (quot < SMIN) begin
            sample = -16'sh8000;
        end else begin
            sample = 16'(quot);
        end
    end

endmodule

@@ src/vag_adpcm_decoder_unit.sv @@
// Top level of the VAG ADPCM decoder: input stage, block sequencing, history and result register.
//
// Decodes a VAG ADPCM stream fed one byte per transfer in 16-byte blocks. Byte 0 of a
// block sets the filter and the shift, byte 1 is the flag byte (7 ends the stream and yields
// one result with sample 0, end_of_stream 1, last 1; after that all bytes are dropped until a
// transfer with restart set), and each of the 14 data bytes yields two samples, low nibble
// first, the second with last set. Header and other flag bytes yield no result. A restart
// transfer clears history and block position and is taken as a header byte. A header, flag
// or dropped byte leaves the stage register once handled; a data byte stays for one filter
// step per nibble through a single filter unit that must finish the first step before the
// second can use the updated history. The result register lets the next byte enter while
// a finished sample waits for m_ready, so a continuous stream of data bytes is bound by
// the output channel, which carries one result per cycle while m_ready is high.
module vag_adpcm_decoder_unit #(
    parameter int FRAC_BITS = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample,
    output logic               m_end_of_stream,
    output logic               m_last
);
    import vad_pkg::*;

    localparam int HIST_BITS = HIST_INT_BITS + FRAC_BITS;

    // stage register: holds the accepted byte while its results are produced
    logic                        stg_valid_reg, stg_valid_next;
    logic [7:0]                  stg_byte_reg;
    logic                        stg_restart_reg;
    logic                        stg_phase_reg, stg_phase_next;

    // decoder state
    logic [POS_W-1:0]            pos_reg, pos_next;
    filt_idx_t                   filt_reg, filt_next;
    logic [3:0]                  shift_reg, shift_next;
    logic signed [HIST_BITS-1:0] hist1_reg, hist1_next;
    logic signed [HIST_BITS-1:0] hist2_reg, hist2_next;
    logic                        stopped_reg, stopped_next;

    // result register
    logic                        m_valid_reg, m_valid_next;
    logic signed [15:0]          m_sample_reg;
    logic                        m_eos_reg;
    logic                        m_last_reg;

    logic [POS_W-1:0]            eff_pos;
    logic                        eff_stopped;
    logic                        is_hdr, is_end, is_data, needs_out;
    logic                        out_free, fire, done;
    logic [3:0]                  cur_nibble;
    logic signed [HIST_BITS-1:0] flt_acc;
    logic signed [15:0]          flt_sample;

    // restart acts before the byte is looked at
    assign eff_pos     = stg_restart_reg ? POS_HEADER : pos_reg;
    assign eff_stopped = stg_restart_reg ? 1'b0 : stopped_reg;

    assign is_hdr    = !eff_stopped && (eff_pos == POS_HEADER);
    assign is_end    = !eff_stopped && (eff_pos == POS_FLAG) && (stg_byte_reg == END_FLAG);
    assign is_data   = !eff_stopped && (eff_pos != POS_HEADER) && (eff_pos != POS_FLAG);
    assign needs_out = is_end || is_data;

    // result register takes a new value when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = stg_valid_reg && (!needs_out || out_free);
    // data bytes finish on their second nibble
    assign done     = fire && (!is_data || stg_phase_reg);

    assign s_ready = !stg_valid_reg || done;

    assign cur_nibble = stg_phase_reg ? stg_byte_reg[7:4] : stg_byte_reg[3:0];

    vad_nibble_filter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_filter (
        .nibble   (cur_nibble),
        .shift    (shift_reg),
        .filt     (filt_reg),
        .hist_one (hist1_reg),
        .hist_two (hist2_reg),
        .acc      (flt_acc),
        .sample   (flt_sample)
    );

    always_comb begin
        stg_valid_next = stg_valid_reg;
        stg_phase_next = stg_phase_reg;
        pos_next       = pos_reg;
        filt_next      = filt_reg;
        shift_next     = shift_reg;
        hist1_next     = hist1_reg;
        hist2_next     = hist2_reg;
        stopped_next   = stopped_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (s_valid && s_ready) begin
            stg_valid_next = 1'b1;
        end else if (done) begin
            stg_valid_next = 1'b0;
        end

        if (fire) begin
            if (stg_restart_reg) begin
                hist1_next   = '0;
                hist2_next   = '0;
                stopped_next = 1'b0;
            end
            if (is_hdr) begin
                filt_next  = filt_select(stg_byte_reg[7:4]);
                shift_next = stg_byte_reg[3:0];
            end
            if (is_end) begin
                stopped_next = 1'b1;
                m_valid_next = 1'b1;
            end
            if (is_data) begin
                hist2_next     = hist1_reg;
                hist1_next     = flt_acc;
                m_valid_next   = 1'b1;
                stg_phase_next = !stg_phase_reg;
            end
        end

        // advance block position once per byte that is not dropped
        if (done && !eff_stopped) begin
            pos_next = (eff_pos == POS_LAST) ? POS_HEADER : eff_pos + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            stg_phase_reg <= 1'b0;
            pos_reg       <= '0;
            filt_reg      <= '0;
            shift_reg     <= '0;
            hist1_reg     <= '0;
            hist2_reg     <= '0;
            stopped_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            stg_phase_reg <= stg_phase_next;
            pos_reg       <= pos_next;
            filt_reg      <= filt_next;
            shift_reg     <= shift_next;
            hist1_reg     <= hist1_next;
            hist2_reg     <= hist2_next;
            stopped_reg   <= stopped_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers: load on transfer or when a result is produced
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stg_byte_reg    <= s_data_byte;
            stg_restart_reg <= s_restart;
        end
        if (fire && needs_out) begin
            m_sample_reg <= is_data ? flt_sample : 16'sd0;
            m_eos_reg    <= is_end;
            m_last_reg   <= is_end || stg_phase_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sample        = m_sample_reg;
    assign m_end_of_stream = m_eos_reg;
    assign m_last          = m_last_reg;

    // end result always closes its byte and carries a zero sample
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_stream |-> m_last && (m_sample == 16'sd0))
        else $error("end result without last or with nonzero sample");

    // first sample of a pair is always followed by the second without a gap
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |=> m_valid)
        else $error("second sample of a data byte missing");

    // second-nibble phase only exists for a data byte in the stage
    a_phase_data: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_phase_reg |-> stg_valid_reg && is_data)
        else $error("second nibble phase outside a data byte");

    // a pending first sample always has its data byte still in the stage
    a_stage_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> stg_valid_reg && stg_phase_reg)
        else $error("data byte left the stage before its second sample");

endmodule
